@@ sv/blrs_pkg.sv @@
package blrs_pkg;

	localparam int unsigned MaxBytesPerRow = 256;
	localparam int unsigned LaneCount      = 8;
	localparam logic [3:0]  BirthCount     = 4'd3;
	localparam logic [3:0]  SurviveCount   = 4'd2;

	// input word: one byte column of three rows
	typedef struct packed {
		logic [7:0] north_byte;
		logic [7:0] centre_byte;
		logic [7:0] south_byte;
		logic       row_end;
	} in_word_t;

	// output word: one next-generation byte of the centre row
	typedef struct packed {
		logic [7:0] next_byte;
		logic [7:0] column;
		logic       row_done;
	} out_word_t;

	// per-cycle control seen by every cell
	typedef struct packed {
		logic load;
		logic clear;
	} cell_ctrl_t;

	// B3/S23 rule on one cell and its eight neighbors
	function automatic logic life_rule(input logic alive, input logic [7:0] nbrs);
		logic [3:0] sum;
		sum = 4'd0;
		for (int k = 0; k < 8; k++) begin
			sum = sum + 4'(nbrs[k]);
		end
		return (sum == BirthCount) || (alive && (sum == SurviveCount));
	endfunction

endpackage

@@ sv/bitpacked_life_row_stepper.sv @@
// Life B3/S23 row stepper, one bit-packed row per pass.
// in channel (in_valid/in_ready/in_data): one word per byte column of the
//   rows above, at and below the row being updated, bit 0 westmost;
//   row_end marks the row's last column.
// out channel (out_valid/out_ready/out_data): next-generation bytes of the
//   centre row with their column index; row_done flags the row's last byte.
// Column c-1 is emitted when column c is taken (c >= 2); the row_end word
// also emits its own column with dead cells to the east. Column 0 is never
// emitted, so a one-column row gives no output.
// A word's first result is valid the cycle after the word is taken.
// Throughput: one word per cycle while out_ready is high; a row_end word
// that yields two results holds in_ready low while the second one drains.
// The eight lane cells and the output register plus one spare slot set
// that figure. A stalled receiver holds in_ready low while the output
// register is full, until out_ready returns; nothing is dropped.
// Reset clears column history, the column counter and both output valid flags.
module bitpacked_life_row_stepper #(
	parameter int unsigned MAX_BYTES_PER_ROW = blrs_pkg::MaxBytesPerRow
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  blrs_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output blrs_pkg::out_word_t out_data
);

	localparam int unsigned CW = (MAX_BYTES_PER_ROW > 2) ? $clog2(MAX_BYTES_PER_ROW) : 1;
	localparam int unsigned NL = blrs_pkg::LaneCount;

	logic                 accept;
	blrs_pkg::cell_ctrl_t ctrl;
	logic [CW-1:0]        col_q;
	logic [2:0]           cur   [NL];
	logic [2:0]           older [NL];
	logic [2:0]           newer [NL];
	logic [NL-1:0]        res_main;
	logic [NL-1:0]        res_last;
	logic                 has_main;
	logic                 has_last;
	blrs_pkg::out_word_t  main_word;
	blrs_pkg::out_word_t  last_word;
	blrs_pkg::out_word_t  out_q;
	blrs_pkg::out_word_t  spare_q;
	logic                 out_valid_q;
	logic                 spare_valid_q;

	assign in_ready  = !spare_valid_q && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign ctrl.load  = accept && !in_data.row_end;
	assign ctrl.clear = accept && in_data.row_end;

	// chain of lane cells, neighbors wired across lanes
	for (genvar i = 0; i < NL; i++) begin : g_lane
		logic [2:0] west_main;
		logic [2:0] east_main;
		logic [2:0] west_last;
		logic [2:0] east_last;

		assign cur[i] = {in_data.south_byte[i], in_data.centre_byte[i],
			in_data.north_byte[i]};

		if (i == 0) begin : g_west_edge
			assign west_main = older[NL-1];
			assign west_last = newer[NL-1];
		end else begin : g_west_inner
			assign west_main = newer[i-1];
			assign west_last = cur[i-1];
		end

		if (i == NL-1) begin : g_east_edge
			assign east_main = cur[0];
			assign east_last = 3'b000;
		end else begin : g_east_inner
			assign east_main = newer[i+1];
			assign east_last = cur[i+1];
		end

		blrs_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.cur       (cur[i]),
			.west_main (west_main),
			.east_main (east_main),
			.west_last (west_last),
			.east_last (east_last),
			.older     (older[i]),
			.newer     (newer[i]),
			.res_main  (res_main[i]),
			.res_last  (res_last[i])
		);
	end

	// column counter, saturating at the last column index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (ctrl.clear) begin
			col_q <= '0;
		end else if (ctrl.load && (col_q < CW'(MAX_BYTES_PER_ROW - 1))) begin
			col_q <= col_q + CW'(1);
		end
	end

	assign has_main = (CW+1)'(col_q) >= (CW+1)'(2);
	assign has_last = in_data.row_end && (col_q != '0);

	assign main_word.next_byte = res_main;
	assign main_word.column    = 8'(col_q - CW'(1));
	assign main_word.row_done  = 1'b0;
	assign last_word.next_byte = res_last;
	assign last_word.column    = 8'(col_q);
	assign last_word.row_done  = 1'b1;

	// output register plus one spare slot for the second result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q   <= has_main || has_last;
			spare_valid_q <= has_main && has_last;
		end else if (out_ready && out_valid_q) begin
			out_valid_q   <= spare_valid_q;
			spare_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q   <= has_main ? main_word : last_word;
			spare_q <= last_word;
		end else if (out_ready && out_valid_q && spare_valid_q) begin
			out_q <= spare_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ sv/blrs_cell.sv @@
// One bit lane: holds its bits of the two previous columns and computes
// its bit of both possible results. Bits are {south, centre, north}.
module blrs_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  blrs_pkg::cell_ctrl_t  ctrl,
	input  logic [2:0]            cur,
	input  logic [2:0]            west_main,
	input  logic [2:0]            east_main,
	input  logic [2:0]            west_last,
	input  logic [2:0]            east_last,
	output logic [2:0]            older,
	output logic [2:0]            newer,
	output logic                  res_main,
	output logic                  res_last
);

	logic [2:0] older_q;
	logic [2:0] newer_q;

	// column history, shifted on every non-final word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q <= '0;
			newer_q <= '0;
		end else if (ctrl.clear) begin
			older_q <= '0;
			newer_q <= '0;
		end else if (ctrl.load) begin
			older_q <= newer_q;
			newer_q <= cur;
		end
	end

	assign older = older_q;
	assign newer = newer_q;

	// middle column is the newer one, east neighbor is the arriving column
	assign res_main = blrs_pkg::life_rule(newer_q[1],
		{west_main, newer_q[0], newer_q[2], east_main});

	// final column of the row, dead cells to the east
	assign res_last = blrs_pkg::life_rule(cur[1],
		{west_last, cur[0], cur[2], east_last});

endmodule
